@@ hdl/ots_pkg.sv @@
// Package for the operator token scanner: scan state codes, token kind codes,
// character codes and the per-request result record. No dependencies.
`default_nettype none

package ots_pkg;

  localparam int unsigned STATE_W = 5;
  localparam int unsigned KIND_W  = 6;

  localparam logic [STATE_W-1:0] S_IDLE    = 5'd0;
  localparam logic [STATE_W-1:0] S_PLUS    = 5'd1;
  localparam logic [STATE_W-1:0] S_MINUS   = 5'd2;
  localparam logic [STATE_W-1:0] S_DIV     = 5'd3;
  localparam logic [STATE_W-1:0] S_MUL     = 5'd4;
  localparam logic [STATE_W-1:0] S_EXP     = 5'd5;
  localparam logic [STATE_W-1:0] S_ASSIGN  = 5'd6;
  localparam logic [STATE_W-1:0] S_MOD     = 5'd7;
  localparam logic [STATE_W-1:0] S_EQUAL   = 5'd8;
  localparam logic [STATE_W-1:0] S_NOT     = 5'd9;
  localparam logic [STATE_W-1:0] S_NOTEQ   = 5'd10;
  localparam logic [STATE_W-1:0] S_GT      = 5'd11;
  localparam logic [STATE_W-1:0] S_LT      = 5'd12;
  localparam logic [STATE_W-1:0] S_AND     = 5'd13;
  localparam logic [STATE_W-1:0] S_OR      = 5'd14;
  localparam logic [STATE_W-1:0] S_SQUOTE  = 5'd15;
  localparam logic [STATE_W-1:0] S_DQUOTE  = 5'd16;
  localparam logic [STATE_W-1:0] S_COMMENT = 5'd17;

  localparam logic [KIND_W-1:0] K_STRICT_NE  = 6'd0;
  localparam logic [KIND_W-1:0] K_STRICT_EQ  = 6'd1;
  localparam logic [KIND_W-1:0] K_INC        = 6'd2;
  localparam logic [KIND_W-1:0] K_DEC        = 6'd3;
  localparam logic [KIND_W-1:0] K_ADD_ASSIGN = 6'd4;
  localparam logic [KIND_W-1:0] K_SUB_ASSIGN = 6'd5;
  localparam logic [KIND_W-1:0] K_MUL_ASSIGN = 6'd6;
  localparam logic [KIND_W-1:0] K_DIV_ASSIGN = 6'd7;
  localparam logic [KIND_W-1:0] K_MOD_ASSIGN = 6'd8;
  localparam logic [KIND_W-1:0] K_EXP_ASSIGN = 6'd9;
  localparam logic [KIND_W-1:0] K_GE         = 6'd10;
  localparam logic [KIND_W-1:0] K_LE         = 6'd11;
  localparam logic [KIND_W-1:0] K_LOG_AND    = 6'd12;
  localparam logic [KIND_W-1:0] K_LOG_OR     = 6'd13;
  localparam logic [KIND_W-1:0] K_SHL        = 6'd14;
  localparam logic [KIND_W-1:0] K_SHR        = 6'd15;
  localparam logic [KIND_W-1:0] K_PLUS       = 6'd16;
  localparam logic [KIND_W-1:0] K_MINUS      = 6'd17;
  localparam logic [KIND_W-1:0] K_DIV        = 6'd18;
  localparam logic [KIND_W-1:0] K_MUL        = 6'd19;
  localparam logic [KIND_W-1:0] K_EXP        = 6'd20;
  localparam logic [KIND_W-1:0] K_ASSIGN     = 6'd21;
  localparam logic [KIND_W-1:0] K_MOD        = 6'd22;
  localparam logic [KIND_W-1:0] K_EQ         = 6'd23;
  localparam logic [KIND_W-1:0] K_NE         = 6'd24;
  localparam logic [KIND_W-1:0] K_GT         = 6'd25;
  localparam logic [KIND_W-1:0] K_LT         = 6'd26;
  localparam logic [KIND_W-1:0] K_BIT_AND    = 6'd27;
  localparam logic [KIND_W-1:0] K_BIT_OR     = 6'd28;
  localparam logic [KIND_W-1:0] K_NOT        = 6'd29;
  localparam logic [KIND_W-1:0] K_DOT        = 6'd30;
  localparam logic [KIND_W-1:0] K_ARROW      = 6'd31;
  localparam logic [KIND_W-1:0] K_NEWLINE    = 6'd32;
  localparam logic [KIND_W-1:0] K_LPAREN     = 6'd33;
  localparam logic [KIND_W-1:0] K_RPAREN     = 6'd34;
  localparam logic [KIND_W-1:0] K_LBRACKET   = 6'd35;
  localparam logic [KIND_W-1:0] K_RBRACKET   = 6'd36;
  localparam logic [KIND_W-1:0] K_LBRACE     = 6'd37;
  localparam logic [KIND_W-1:0] K_RBRACE     = 6'd38;
  localparam logic [KIND_W-1:0] K_SQ_STRING  = 6'd39;
  localparam logic [KIND_W-1:0] K_DQ_STRING  = 6'd40;
  localparam logic [KIND_W-1:0] K_COLON      = 6'd41;
  localparam logic [KIND_W-1:0] K_SEMI       = 6'd42;
  localparam logic [KIND_W-1:0] K_COMMENT    = 6'd43;
  localparam logic [KIND_W-1:0] K_FAILED     = 6'd44;
  localparam logic [KIND_W-1:0] K_NONE       = 6'd0;

  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_PIPE     = 8'h7C;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;

  typedef struct packed {
    logic              token_valid;
    logic [KIND_W-1:0] token_kind;
    logic              char_consumed;
  } ots_result_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } ots_item_t;

endpackage

`default_nettype wire

@@ hdl/ots_in_reg.sv @@
// Input register of the operator token scanner with its valid flag.
// Depends on ots_pkg.
`default_nettype none

module ots_in_reg
  import ots_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ots_item_t  in_item,
  input  wire logic       advance,
  output logic            item_valid,
  output ots_item_t       item
);

  logic      valid_r;
  logic      valid_nxt;
  ots_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !advance);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ots_scan_core.sv @@
// Scan state register and longest-match next-state logic of the scanner.
// Depends on ots_pkg.
`default_nettype none

module ots_scan_core
  import ots_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ots_item_t item,
  input  wire logic      advance,
  output ots_result_t    result
);

  logic [STATE_W-1:0] state_r;
  logic [STATE_W-1:0] state_nxt;
  logic               eoi;
  logic [7:0]         ch;

  assign eoi = item.end_of_input;
  assign ch  = item.char_code;

  always_comb begin
    logic is_eq;
    logic is_nl;
    is_eq     = !eoi && (ch == CH_EQUAL);
    is_nl     = !eoi && (ch == CH_NEWLINE);
    result    = '{token_valid: 1'b1, token_kind: K_FAILED, char_consumed: 1'b0};
    state_nxt = S_IDLE;
    case (state_r)
      S_PLUS: begin
        if (!eoi && ch == CH_PLUS) begin
          result = '{1'b1, K_INC, 1'b1};
        end else if (is_eq) begin
          result = '{1'b1, K_ADD_ASSIGN, 1'b1};
        end else begin
          result = '{1'b1, K_PLUS, 1'b0};
        end
      end
      S_MINUS: begin
        if (!eoi && ch == CH_MINUS) begin
          result = '{1'b1, K_DEC, 1'b1};
        end else if (is_eq) begin
          result = '{1'b1, K_SUB_ASSIGN, 1'b1};
        end else if (!eoi && ch == CH_GT) begin
          result = '{1'b1, K_ARROW, 1'b1};
        end else begin
          result = '{1'b1, K_MINUS, 1'b0};
        end
      end
      S_DIV: begin
        if (is_eq) begin
          result = '{1'b1, K_DIV_ASSIGN, 1'b1};
        end else if (!eoi && ch == CH_SLASH) begin
          result    = '{1'b0, K_NONE, 1'b1};
          state_nxt = S_COMMENT;
        end else begin
          result = '{1'b1, K_DIV, 1'b0};
        end
      end
      S_MUL: begin
        if (is_eq) begin
          result = '{1'b1, K_MUL_ASSIGN, 1'b1};
        end else if (!eoi && ch == CH_STAR) begin
          result    = '{1'b0, K_NONE, 1'b1};
          state_nxt = S_EXP;
        end else begin
          result = '{1'b1, K_MUL, 1'b0};
        end
      end
      S_EXP: begin
        result = is_eq ? ots_result_t'{1'b1, K_EXP_ASSIGN, 1'b1}
                       : ots_result_t'{1'b1, K_EXP, 1'b0};
      end
      S_MOD: begin
        result = is_eq ? ots_result_t'{1'b1, K_MOD_ASSIGN, 1'b1}
                       : ots_result_t'{1'b1, K_MOD, 1'b0};
      end
      S_ASSIGN: begin
        if (is_eq) begin
          result    = '{1'b0, K_NONE, 1'b1};
          state_nxt = S_EQUAL;
        end else begin
          result = '{1'b1, K_ASSIGN, 1'b0};
        end
      end
      S_EQUAL: begin
        result = is_eq ? ots_result_t'{1'b1, K_STRICT_EQ, 1'b1}
                       : ots_result_t'{1'b1, K_EQ, 1'b0};
      end
      S_NOT: begin
        if (is_eq) begin
          result    = '{1'b0, K_NONE, 1'b1};
          state_nxt = S_NOTEQ;
        end else begin
          result = '{1'b1, K_NOT, 1'b0};
        end
      end
      S_NOTEQ: begin
        result = is_eq ? ots_result_t'{1'b1, K_STRICT_NE, 1'b1}
                       : ots_result_t'{1'b1, K_NE, 1'b0};
      end
      S_GT: begin
        if (is_eq) begin
          result = '{1'b1, K_GE, 1'b1};
        end else if (!eoi && ch == CH_GT) begin
          result = '{1'b1, K_SHR, 1'b1};
        end else begin
          result = '{1'b1, K_GT, 1'b0};
        end
      end
      S_LT: begin
        if (is_eq) begin
          result = '{1'b1, K_LE, 1'b1};
        end else if (!eoi && ch == CH_LT) begin
          result = '{1'b1, K_SHL, 1'b1};
        end else begin
          result = '{1'b1, K_LT, 1'b0};
        end
      end
      S_AND: begin
        result = (!eoi && ch == CH_AMP) ? ots_result_t'{1'b1, K_LOG_AND, 1'b1}
                                        : ots_result_t'{1'b1, K_BIT_AND, 1'b0};
      end
      S_OR: begin
        result = (!eoi && ch == CH_PIPE) ? ots_result_t'{1'b1, K_LOG_OR, 1'b1}
                                         : ots_result_t'{1'b1, K_BIT_OR, 1'b0};
      end
      S_SQUOTE, S_DQUOTE: begin
        if (eoi || is_nl) begin
          result = '{1'b1, K_FAILED, 1'b0};
        end else if (state_r == S_SQUOTE && ch == CH_SQUOTE) begin
          result = '{1'b1, K_SQ_STRING, 1'b1};
        end else if (state_r == S_DQUOTE && ch == CH_DQUOTE) begin
          result = '{1'b1, K_DQ_STRING, 1'b1};
        end else begin
          result    = '{1'b0, K_NONE, 1'b1};
          state_nxt = state_r;
        end
      end
      S_COMMENT: begin
        if (eoi || is_nl) begin
          result = '{1'b1, K_COMMENT, 1'b0};
        end else begin
          result    = '{1'b0, K_NONE, 1'b1};
          state_nxt = S_COMMENT;
        end
      end
      default: begin
        if (eoi) begin
          result = '{1'b1, K_FAILED, 1'b0};
        end else begin
          result = '{1'b0, K_NONE, 1'b1};
          case (ch)
            CH_PLUS:     state_nxt = S_PLUS;
            CH_MINUS:    state_nxt = S_MINUS;
            CH_SLASH:    state_nxt = S_DIV;
            CH_STAR:     state_nxt = S_MUL;
            CH_EQUAL:    state_nxt = S_ASSIGN;
            CH_PERCENT:  state_nxt = S_MOD;
            CH_GT:       state_nxt = S_GT;
            CH_LT:       state_nxt = S_LT;
            CH_AMP:      state_nxt = S_AND;
            CH_PIPE:     state_nxt = S_OR;
            CH_BANG:     state_nxt = S_NOT;
            CH_SQUOTE:   state_nxt = S_SQUOTE;
            CH_DQUOTE:   state_nxt = S_DQUOTE;
            CH_DOT:      result = '{1'b1, K_DOT, 1'b1};
            CH_NEWLINE:  result = '{1'b1, K_NEWLINE, 1'b1};
            CH_LPAREN:   result = '{1'b1, K_LPAREN, 1'b1};
            CH_RPAREN:   result = '{1'b1, K_RPAREN, 1'b1};
            CH_LBRACKET: result = '{1'b1, K_LBRACKET, 1'b1};
            CH_RBRACKET: result = '{1'b1, K_RBRACKET, 1'b1};
            CH_LBRACE:   result = '{1'b1, K_LBRACE, 1'b1};
            CH_RBRACE:   result = '{1'b1, K_RBRACE, 1'b1};
            CH_COLON:    result = '{1'b1, K_COLON, 1'b1};
            CH_SEMI:     result = '{1'b1, K_SEMI, 1'b1};
            default:     result = '{1'b1, K_FAILED, 1'b0};
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ots_out_reg.sv @@
// Result register of the scanner: holds one result until the consumer takes it.
// Depends on ots_pkg.
`default_nettype none

module ots_out_reg
  import ots_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_valid,
  input  wire ots_result_t result,
  output logic             advance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ots_result_t      out_result
);

  logic        valid_r;
  logic        valid_nxt;
  ots_result_t result_r;

  assign advance    = item_valid && (!valid_r || out_ready);
  assign valid_nxt  = advance || (valid_r && !out_ready);
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

endmodule

`default_nettype wire

@@ hdl/operator_token_scanner_unit.sv @@
// Top level of the operator token scanner: input register, scan core, result register.
// Depends on ots_pkg, ots_in_reg, ots_scan_core and ots_out_reg.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   in_char_code[7:0], in_end_of_input
//   out_      output     out_valid / out_ready out_token_valid, out_token_kind[5:0],
//                                              out_char_consumed
//
// One request is accepted per cycle while in_ready is high; its result is registered.
// The scan state register is read and written in the stage between the
// input register and the result register, which sets the rate of one per cycle.
// Reset returns the scan state to idle and empties both registers.
// A stalled result holds; the input register takes one more request and then
// in_ready stays low until out_ready returns.
`default_nettype none

module operator_token_scanner_unit
  import ots_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_char_code,
  input  wire logic              in_end_of_input,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_token_valid,
  output logic [KIND_W-1:0]      out_token_kind,
  output logic                   out_char_consumed
);

  ots_item_t   in_item;
  ots_item_t   item;
  logic        item_valid;
  logic        advance;
  ots_result_t result;
  ots_result_t out_result;

  assign in_item = '{char_code: in_char_code, end_of_input: in_end_of_input};

  ots_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ots_scan_core u_scan_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  ots_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_token_valid   = out_result.token_valid;
  assign out_token_kind    = out_result.token_kind;
  assign out_char_consumed = out_result.char_consumed;

endmodule

`default_nettype wire

@@ hdl/ots_checker.sv @@
// Port-level checks for the operator token scanner, bound to the top level.
// Depends on ots_pkg and operator_token_scanner_unit.
`default_nettype none

module ots_checker
  import ots_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_token_valid,
  input wire logic [KIND_W-1:0] out_token_kind,
  input wire logic              out_char_consumed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_valid)
      && $stable(out_token_kind) && $stable(out_char_consumed))
    else $error("Stalled result changed.");

  a_open_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_token_valid |-> out_token_kind == K_NONE && out_char_consumed)
    else $error("Open token must show kind zero and a consumed character.");

  a_failed_unused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_valid && out_token_kind == K_FAILED |-> !out_char_consumed)
    else $error("Failed token must not consume the character.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= K_FAILED)
    else $error("Token kind out of range.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind operator_token_scanner_unit ots_checker u_ots_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_token_valid   (out_token_valid),
  .out_token_kind    (out_token_kind),
  .out_char_consumed (out_char_consumed)
);

`default_nettype wire
